// ===== src/ckfp_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte update for the key frame parser.
`timescale 1ns / 1ps
`default_nettype none

package ckfp_pkg;

  localparam int NUM_KEYS    = 6;
  localparam int FRAME_LEN   = NUM_KEYS + 11;
  localparam int MOD_FIRST   = 1;
  localparam int MOD_COUNT   = 8;
  localparam int KEY_FIRST   = 9;
  localparam int COUNT_W     = 6;
  localparam int KEY_INDEX_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [15:0]        CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]        CRC_POLY  = 16'hA001;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_KEY    = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_CRC    = 2'd2
  } err_code_t;

  typedef struct packed {
    err_code_t                   err;
    logic [15:0]                 crc_calc;
    logic [15:0]                 crc_rcvd;
    logic [7:0]                  state_code;
    logic [7:0]                  modifier_bits;
    logic                        all_released;
    logic [NUM_KEYS-1:0][7:0]    keys;
  } ckfp_frame_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/crc_checked_key_frame_parser_core.sv =====
// Top level of the CRC-checked key frame parser.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per transaction and takes a byte in every cycle while
// end_of_frame is low. The byte with end_of_frame high is checked in the same
// cycle for length and CRC-16/Modbus, and its results sit in the result register
// in the next cycle. A good frame gives a header and then NUM_KEYS key results, one
// per cycle while out_ready is high; a bad frame gives a single header with the
// error code. The next end-of-frame byte is taken once the result register is free
// or its final result is taken in that cycle, so the result register's drain sets
// the pace only for frames shorter than NUM_KEYS + 1 bytes.
module crc_checked_key_frame_parser_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          end_of_frame,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               item_kind,
  output logic [ckfp_pkg::KEY_INDEX_W-1:0]   key_index,
  output logic [7:0]                         key_code,
  output logic [7:0]                         state_code,
  output logic [7:0]                         modifier_bits,
  output logic [1:0]                         error_code,
  output logic [15:0]                        crc_calc,
  output logic [15:0]                        crc_rcvd,
  output logic                               all_released,
  output logic                               last_result
);
  import ckfp_pkg::*;

  logic        emit_free;
  logic        frame_load;
  ckfp_frame_t frame;

  ckfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_frame (end_of_frame),
    .emit_free    (emit_free),
    .frame_load   (frame_load),
    .frame        (frame)
  );

  ckfp_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .frame_load    (frame_load),
    .frame         (frame),
    .emit_free     (emit_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .key_index     (key_index),
    .key_code      (key_code),
    .state_code    (state_code),
    .modifier_bits (modifier_bits),
    .error_code    (error_code),
    .crc_calc      (crc_calc),
    .crc_rcvd      (crc_rcvd),
    .all_released  (all_released),
    .last_result   (last_result)
  );

  a_eof_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_frame |=> out_valid)
    else $error("End-of-frame transaction did not produce a result.");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (item_kind == KIND_HEADER) && (error_code != ERR_NONE) |-> last_result)
    else $error("Error header is not the final result of its frame.");

  a_key_follows_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (item_kind == KIND_HEADER) && !last_result
    |=> out_valid && (item_kind == KIND_KEY) && (key_index == '0))
    else $error("Good header was not followed by the first key result.");

  a_key_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (item_kind == KIND_KEY) |-> (error_code == ERR_NONE) && !all_released)
    else $error("Key result carries header fields.");

endmodule

`default_nettype wire

// ===== src/ckfp_parser.sv =====
// Byte-level frame parser: CRC, field capture, length and CRC checks on the last byte.
`timescale 1ns / 1ps
`default_nettype none

module ckfp_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_frame,
  input  wire logic               emit_free,
  output logic                    frame_load,
  output ckfp_pkg::ckfp_frame_t   frame
);
  import ckfp_pkg::*;

  logic [COUNT_W-1:0]        byte_count;
  logic [15:0]               running_crc;
  logic [15:0]               crc_tail;
  logic                      long_flag;
  logic [7:0]                state_value;
  logic [7:0]                modifier_store;
  logic [NUM_KEYS-1:0][7:0]  key_store;

  logic [COUNT_W-1:0] byte_count_next;
  logic [15:0]        running_crc_next;
  logic [15:0]        crc_tail_next;
  logic               long_flag_next;
  logic               accept;
  logic               len_bad;
  logic               crc_bad;
  logic               keys_zero;

  assign in_ready   = !end_of_frame || emit_free;
  assign accept     = in_valid && in_ready;
  assign frame_load = accept && end_of_frame;

  always_comb begin
    running_crc_next = (byte_count >= COUNT_W'(2)) ?
                       crc16_byte(running_crc, crc_tail[7:0]) : running_crc;
    crc_tail_next    = {data_byte, crc_tail[15:8]};
    long_flag_next   = long_flag || (byte_count == COUNT_MAX);
    byte_count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_W'(1);
  end

  always_comb begin
    keys_zero = 1'b1;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (key_store[i] != 8'h00) begin
        keys_zero = 1'b0;
      end
    end
    len_bad = long_flag_next || (byte_count != COUNT_W'(FRAME_LEN - 1));
    crc_bad = running_crc_next != crc_tail_next;

    frame.keys          = key_store;
    frame.crc_calc      = len_bad ? 16'h0000 : running_crc_next;
    frame.crc_rcvd      = len_bad ? 16'h0000 : crc_tail_next;
    frame.state_code    = 8'h00;
    frame.modifier_bits = 8'h00;
    frame.all_released  = 1'b0;
    if (len_bad) begin
      frame.err = ERR_LENGTH;
    end else if (crc_bad) begin
      frame.err = ERR_CRC;
    end else begin
      frame.err           = ERR_NONE;
      frame.state_code    = state_value;
      frame.modifier_bits = modifier_store;
      frame.all_released  = (modifier_store == 8'h00) && keys_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_crc    <= CRC_INIT;
      crc_tail       <= 16'h0000;
      long_flag      <= 1'b0;
      state_value    <= 8'h00;
      modifier_store <= 8'h00;
    end else if (accept) begin
      if (byte_count == COUNT_W'(0)) begin
        state_value <= data_byte;
      end
      for (int i = 0; i < MOD_COUNT; i++) begin
        if (byte_count == COUNT_W'(MOD_FIRST + i)) begin
          modifier_store[i] <= (data_byte != 8'h00);
        end
      end
      if (end_of_frame) begin
        byte_count  <= '0;
        running_crc <= CRC_INIT;
        crc_tail    <= 16'h0000;
        long_flag   <= 1'b0;
      end else begin
        byte_count  <= byte_count_next;
        running_crc <= running_crc_next;
        crc_tail    <= crc_tail_next;
        long_flag   <= long_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (byte_count == COUNT_W'(KEY_FIRST + i)) begin
          key_store[i] <= data_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ckfp_emitter.sv =====
// Result register that sends the header and, for a good frame, the key results of one checked frame.
`timescale 1ns / 1ps
`default_nettype none

module ckfp_emitter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               frame_load,
  input  wire ckfp_pkg::ckfp_frame_t              frame,
  output logic                                    emit_free,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    item_kind,
  output logic [ckfp_pkg::KEY_INDEX_W-1:0]        key_index,
  output logic [7:0]                              key_code,
  output logic [7:0]                              state_code,
  output logic [7:0]                              modifier_bits,
  output logic [1:0]                              error_code,
  output logic [15:0]                             crc_calc,
  output logic [15:0]                             crc_rcvd,
  output logic                                    all_released,
  output logic                                    last_result
);
  import ckfp_pkg::*;

  logic                      busy;
  logic                      in_header;
  logic [KEY_INDEX_W-1:0]    key_pos;
  ckfp_frame_t               held;

  assign out_valid     = busy;
  assign item_kind     = in_header ? KIND_HEADER : KIND_KEY;
  assign key_index     = in_header ? '0 : key_pos;
  assign key_code      = in_header ? 8'h00 : held.keys[0];
  assign state_code    = in_header ? held.state_code : 8'h00;
  assign modifier_bits = in_header ? held.modifier_bits : 8'h00;
  assign error_code    = in_header ? held.err : ERR_NONE;
  assign crc_calc      = in_header ? held.crc_calc : 16'h0000;
  assign crc_rcvd      = in_header ? held.crc_rcvd : 16'h0000;
  assign all_released  = in_header ? held.all_released : 1'b0;
  assign last_result   = in_header ? (held.err != ERR_NONE)
                                   : (key_pos == KEY_INDEX_W'(NUM_KEYS - 1));
  assign emit_free     = !busy || (out_ready && last_result);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      in_header <= 1'b0;
      key_pos   <= '0;
    end else if (frame_load) begin
      busy      <= 1'b1;
      in_header <= 1'b1;
      key_pos   <= '0;
    end else if (busy && out_ready) begin
      if (last_result) begin
        busy <= 1'b0;
      end else if (in_header) begin
        in_header <= 1'b0;
        key_pos   <= '0;
      end else begin
        key_pos <= key_pos + KEY_INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_load) begin
      held <= frame;
    end else if (busy && out_ready && !in_header) begin
      for (int i = 0; i < NUM_KEYS - 1; i++) begin
        held.keys[i] <= held.keys[i + 1];
      end
    end
  end

endmodule

`default_nettype wire
